// ===== design/ccs_pkg.sv =====
`default_nettype none

package ccs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4
  } scan_mode_t;

  // One output word: text byte plus end-of-run flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  // What the scanner produces for one input byte.
  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    scan_mode_t mode;
    logic       code_on_line;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== design/c_comment_stripper.sv =====
`default_nettype none

// Streaming C/C++ comment remover. Takes one source byte per cycle and emits the
// comment-free text; a byte that yields two words (a held slash released before
// an ordinary byte) pushes both into a four-word output queue in one go, so
// sustained input rate is one byte per cycle unless the sink stalls.
// Input is taken whenever the queue has room for two words. Results are
// registered in the output queue; out_run_end marks the last word a byte caused.
// A byte with in_text_end set flushes a held slash and returns the block to its
// reset state, dropping any unterminated comment.

module c_comment_stripper
  import ccs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_text_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_end
);

  scan_mode_t mode_r, mode_nxt;
  logic       col_r, col_nxt;
  scan_res_t  res;
  logic       in_acc;
  logic [1:0] push_n;
  out_word_t  w0, w1, ow;
  logic       room2;

  ccs_scan u_scan (
    .mode         (mode_r),
    .code_on_line (col_r),
    .in_byte      (in_byte),
    .in_text_end  (in_text_end),
    .res          (res)
  );

  assign in_ready = room2;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    push_n   = in_acc ? res.n : 2'd0;
    w0.data  = res.b0;
    w0.last  = (res.n == 2'd1);
    w1.data  = res.b1;
    w1.last  = 1'b1;
    mode_nxt = in_acc ? res.mode : mode_r;
    col_nxt  = in_acc ? res.code_on_line : col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      col_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      col_r  <= col_nxt;
    end
  end

  ccs_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push_w0   (w0),
    .push_w1   (w1),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (ow)
  );

  assign out_byte    = ow.data;
  assign out_run_end = ow.last;

  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_text_end) |=> (mode_r == MODE_NORMAL && !col_r))
    else $error("final byte did not return scanner to reset state");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && $past(rst_n)) |=> (mode_r == $past(mode_r) && col_r == $past(col_r)))
    else $error("scanner state moved without an accepted word");

  a_line_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_LINE) |-> (res.n == 2'd0))
    else $error("line comment produced output");

endmodule

`default_nettype wire

// ===== design/ccs_scan.sv =====
`default_nettype none

module ccs_scan
  import ccs_pkg::*;
(
  input  wire scan_mode_t mode,
  input  wire logic       code_on_line,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_text_end,
  output scan_res_t       res
);

  always_comb begin
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    scan_mode_t m;
    logic       col;
    logic       plain;
    n     = 2'd0;
    b0    = 8'h00;
    b1    = 8'h00;
    m     = mode;
    col   = code_on_line;
    plain = 1'b0;

    unique case (mode)
      MODE_SLASH: begin
        if (in_byte == CH_SLASH) begin
          m = MODE_LINE;
          if (code_on_line) begin
            n  = 2'd1;
            b0 = CH_NL;
          end
        end else if (in_byte == CH_STAR) begin
          m = MODE_BLOCK_STAR;
        end else begin
          // Held slash was ordinary text: release it, then treat the byte as code.
          m     = MODE_NORMAL;
          col   = 1'b1;
          n     = 2'd1;
          b0    = CH_SLASH;
          plain = 1'b1;
        end
      end
      MODE_LINE: begin
        if (in_byte == CH_NL) m = MODE_NORMAL;
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (mode == MODE_BLOCK_STAR && in_byte == CH_SLASH) begin
          m = MODE_NORMAL;
        end else begin
          m = (in_byte == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
          if (in_byte == CH_NL) begin
            n  = 2'd1;
            b0 = CH_NL;
          end
        end
      end
      default: begin
        m     = MODE_NORMAL;
        plain = 1'b1;
      end
    endcase

    if (plain) begin
      if (in_byte == CH_SLASH) begin
        m = MODE_SLASH;
      end else begin
        col = (in_byte != CH_NL);
        if (n == 2'd0) begin
          b0 = in_byte;
        end else begin
          b1 = in_byte;
        end
        n = n + 2'd1;
      end
    end

    if (in_text_end) begin
      // Flush a held slash, then return to the reset state.
      if (m == MODE_SLASH) begin
        if (n == 2'd0) begin
          b0 = CH_SLASH;
        end else begin
          b1 = CH_SLASH;
        end
        n = n + 2'd1;
      end
      m   = MODE_NORMAL;
      col = 1'b0;
    end

    res.n            = n;
    res.b0           = b0;
    res.b1           = b1;
    res.mode         = m;
    res.code_on_line = col;
  end

endmodule

`default_nettype wire

// ===== design/ccs_out_fifo.sv =====
`default_nettype none

module ccs_out_fifo
  import ccs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [1:0] push_n,
  input  wire out_word_t  push_w0,
  input  wire out_word_t  push_w1,
  output logic            room2,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_word_t       out_word
);

  out_word_t  mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 3'd0);
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= 3'd2);
  assign out_word  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[wr_ptr_r] <= push_w0;
    if (push_n == 2'd2) mem_r[wr_ptr_r + 2'd1] <= push_w1;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("output queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_n != 2'd0) |-> room2)
    else $error("push into full output queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((wr_ptr_r - rd_ptr_r) == count_r[1:0]))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== tb/ccs_checker.sv =====
`timescale 1ns / 1ps

module ccs_checker
  import ccs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_text_end,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       out_run_end,
  output int              fail_count,
  output int              words_pending
);

  scan_mode_t mode;
  logic       code_line;
  out_word_t  stripped_q[$];
  int         bad_words;

  // Advance the stripper state by one byte and queue the words it yields.
  task automatic strip_byte(input logic [7:0] b, input logic fin);
    logic [7:0] got[$];
    logic       as_plain;
    out_word_t  w;
    as_plain = 1'b0;
    case (mode)
      MODE_SLASH: begin
        if (b == CH_SLASH) begin
          mode = MODE_LINE;
          if (code_line) got.push_back(CH_NL);
        end else if (b == CH_STAR) begin
          // the opening star counts, so a slash right after closes
          mode = MODE_BLOCK_STAR;
        end else begin
          mode      = MODE_NORMAL;
          code_line = 1'b1;
          got.push_back(CH_SLASH);
          as_plain  = 1'b1;
        end
      end
      MODE_LINE: begin
        if (b == CH_NL) mode = MODE_NORMAL;
      end
      MODE_BLOCK, MODE_BLOCK_STAR: begin
        if (mode == MODE_BLOCK_STAR && b == CH_SLASH) begin
          mode = MODE_NORMAL;
        end else begin
          mode = (b == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
          if (b == CH_NL) got.push_back(CH_NL);
        end
      end
      default: begin
        mode     = MODE_NORMAL;
        as_plain = 1'b1;
      end
    endcase

    if (as_plain) begin
      if (b == CH_SLASH) begin
        mode = MODE_SLASH;
      end else begin
        code_line = (b != CH_NL);
        got.push_back(b);
      end
    end

    // final byte: release a held slash, drop any open comment
    if (fin) begin
      if (mode == MODE_SLASH) got.push_back(CH_SLASH);
      mode      = MODE_NORMAL;
      code_line = 1'b0;
    end

    foreach (got[i]) begin
      w.data = got[i];
      w.last = (i == got.size() - 1);
      stripped_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      mode      = MODE_NORMAL;
      code_line = 1'b0;
      stripped_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (stripped_q.size() == 0) begin
          if (bad_words < 10)
            $display("unexpected word: byte %h end %b", out_byte, out_run_end);
          bad_words++;
        end else begin
          want = stripped_q.pop_front();
          if (out_byte !== want.data || out_run_end !== want.last) begin
            if (bad_words < 10)
              $display("mismatch: expected byte %h end %b, got byte %h end %b",
                       want.data, want.last, out_byte, out_run_end);
            bad_words++;
          end
        end
      end
      if (in_valid && in_ready) strip_byte(in_byte, in_text_end);
    end
    fail_count    <= bad_words;
    words_pending <= stripped_q.size();
  end

endmodule

// ===== tb/c_comment_stripper_test.sv =====
`timescale 1ns / 1ps

module c_comment_stripper_test;
  import ccs_pkg::*;

  localparam int WATCHDOG   = 3000;
  localparam int SEGMENTS   = 12;
  localparam int SEG_ITEMS  = 100;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_byte;
  logic       in_text_end;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_end;

  int fail_count;
  int words_pending;
  int idle_cycles = 0;
  int sink_hold   = 0;
  bit steady      = 1'b0;

  c_comment_stripper u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_text_end(in_text_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_run_end(out_run_end)
  );

  ccs_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_byte      (in_byte),
    .in_text_end  (in_text_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_end  (out_run_end),
    .fail_count   (fail_count),
    .words_pending(words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Text-like bytes: lots of comment delimiters and newlines, some raw noise.
  function automatic logic [7:0] pick_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return CH_SLASH;
    if (r < 38) return CH_STAR;
    if (r < 52) return CH_NL;
    if (r < 88) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(0, 255));
  endfunction

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 99) < 30) sink_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic fin);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_byte     <= b;
    in_text_end <= fin;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every expected word is out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
  endtask

  initial begin
    string seq;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_byte     = 8'h00;
    in_text_end = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // code, line comment after code, blank-line line comment, block comment
    // with newline, slash-star-slash close, held slash before newline
    seq = "a//x\n\n//\n/*q\n*//*/\n/\n";
    foreach (seq[i]) send_word(seq[i], 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(CH_SLASH, 1'b1);
    send_word(CH_SLASH, 1'b0);
    send_word(CH_STAR, 1'b0);
    send_word("z", 1'b1);
    drain();

    for (int s = 0; s < SEGMENTS; s++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (s == SEGMENTS / 2) drain();
      for (int i = 0; i < SEG_ITEMS; i++)
        send_word(pick_text_byte(), $urandom_range(0, 49) == 0);
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    do @(posedge clk); while (words_pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
